/* sv/vem_pkg.sv */
`timescale 1ns / 1ps
package vem_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_LENGTH  = 65536;
    localparam int CNT_W       = 17;
    localparam int SQ_W        = 50;
    localparam int XS_W        = 33;
    localparam int OUT_W       = 51;
    localparam int DVD_W       = 82;
    localparam int DVS_W       = 33;
    localparam int DIV_CNT_W   = 7;
    localparam int DIV_STEPS   = 82;
    localparam int RT_W        = 41;
    localparam int SQ_REM_W    = 43;
    localparam int SQRT_CNT_W  = 6;
    localparam int SQRT_STEPS  = 41;
    localparam int PROD_W      = 58;

    localparam logic [1:0] MODE_MSE  = 2'd0;
    localparam logic [1:0] MODE_RMSE = 2'd1;
    localparam logic [1:0] MODE_REL  = 2'd2;

    localparam logic [1:0] FLAG_OK    = 2'd0;
    localparam logic [1:0] FLAG_EMPTY = 2'd1;
    localparam logic [1:0] FLAG_ZERO  = 2'd2;
    localparam logic [1:0] FLAG_SAT   = 2'd3;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic signed [15:0] x_sample;
        logic signed [15:0] y_sample;
        logic               last_pair;
    } in_word_t;

    typedef struct packed {
        logic signed [50:0] error_value;
        logic [1:0]         error_flag;
    } out_word_t;

    typedef struct packed {
        logic acc;
        logic start_div1;
        logic start_sqrt;
        logic load_prod;
        logic start_div2;
        logic load_out;
    } vem_cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic n_zero;
        logic x_zero;
        logic mode_root;
        logic mode_rel;
        logic out_free;
    } vem_status_t;

endpackage

/* sv/vem_div.sv */
`timescale 1ns / 1ps
module vem_div
    import vem_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]     qr_reg, qr_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;
    logic [DVS_W:0]       shifted;
    logic [DVS_W:0]       trial;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        shifted   = {rem_reg, qr_reg[DVD_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        qr_next   = qr_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            qr_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DVS_W])
            begin
                rem_next = trial[DVS_W-1:0];
                qr_next  = {qr_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DVS_W-1:0];
                qr_next  = {qr_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qr_reg  <= qr_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = qr_reg;

    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> ##(DIV_STEPS) done)
        else $error("divider done not on time");

endmodule

/* sv/vem_sqrt.sv */
`timescale 1ns / 1ps
module vem_sqrt
    import vem_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] radicand,
    output logic             done,
    output logic [RT_W-1:0]  root
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [SQRT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]      rad_reg, rad_next;
    logic [SQ_REM_W-1:0]   rem_reg, rem_next;
    logic [RT_W-1:0]       root_reg, root_next;
    logic [SQ_REM_W+1:0]   shifted;
    logic [SQ_REM_W+1:0]   trial;
    logic [SQ_REM_W+1:0]   diff;

    // two radicand bits per cycle
    always_comb
    begin
        shifted   = {rem_reg, rad_reg[DVD_W-1 -: 2]};
        trial     = (SQ_REM_W+2)'({root_reg, 2'b01});
        diff      = shifted - trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            if (shifted >= trial)
            begin
                rem_next  = diff[SQ_REM_W-1:0];
                root_next = {root_reg[RT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[SQ_REM_W-1:0];
                root_next = {root_reg[RT_W-2:0], 1'b0};
            end
            rad_next = {rad_reg[DVD_W-3:0], 2'b00};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == SQRT_CNT_W'(SQRT_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

    a_sqrt_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> ##(SQRT_STEPS) done)
        else $error("square root done not on time");

endmodule

/* sv/vem_dp.sv */
`timescale 1ns / 1ps
module vem_dp
    import vem_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  vem_cmd_t    cmd,
    output vem_status_t status,
    input  in_word_t    in_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_word_t   out_data
);

    logic [1:0]              mode_reg;
    logic [SQ_W-1:0]         sq_sum_reg, sq_sum_next;
    logic signed [XS_W-1:0]  x_sum_reg, x_sum_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [PROD_W-1:0]       prod_reg;
    logic                    out_valid_reg, out_valid_next;
    out_word_t               out_word_reg, out_word_next;

    logic signed [SAMPLE_BITS-1:0] xs, ys;
    logic signed [SAMPLE_BITS:0]   diff, neg_diff;
    logic [SAMPLE_BITS-1:0]        mag;
    logic [2*SAMPLE_BITS-1:0]      sq;
    logic                          room;
    logic [DVS_W-1:0]              x_mag;
    logic                          div_start;
    logic [DVD_W-1:0]              div_dividend, quot;
    logic [DVS_W-1:0]              div_divisor;
    logic                          div_done, sqrt_done;
    logic [RT_W-1:0]               root;
    logic [OUT_W-1:0]              neg_p;

    assign xs       = in_data.x_sample[SAMPLE_BITS-1:0];
    assign ys       = in_data.y_sample[SAMPLE_BITS-1:0];
    assign diff     = {xs[SAMPLE_BITS-1], xs} - {ys[SAMPLE_BITS-1], ys};
    assign neg_diff = -diff;
    assign mag      = diff[SAMPLE_BITS] ? neg_diff[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];
    assign sq       = mag * mag;
    assign room     = count_reg < CNT_W'(MAX_LENGTH);
    assign x_mag    = x_sum_reg[XS_W-1] ? DVS_W'(-x_sum_reg) : DVS_W'(x_sum_reg);

    always_comb
    begin
        sq_sum_next = sq_sum_reg;
        x_sum_next  = x_sum_reg;
        count_next  = count_reg;
        if (cmd.load_out)
        begin
            sq_sum_next = '0;
            x_sum_next  = '0;
            count_next  = '0;
        end
        else if (cmd.acc && room)
        begin
            sq_sum_next = sq_sum_reg + SQ_W'(sq);
            x_sum_next  = x_sum_reg + {{(XS_W-SAMPLE_BITS){xs[SAMPLE_BITS-1]}}, xs};
            count_next  = count_reg + 1'b1;
        end
    end

    // shared divider: first mean, then root times count over the magnitude of the sum of x
    assign div_start = cmd.start_div1 | cmd.start_div2;
    always_comb
    begin
        if (cmd.start_div2)
        begin
            div_dividend = DVD_W'(prod_reg);
            div_divisor  = x_mag;
        end
        else
        begin
            div_dividend = status.mode_root ? {sq_sum_reg, 32'd0}
                                            : DVD_W'({sq_sum_reg, 16'd0});
            div_divisor  = DVS_W'(count_reg);
        end
    end

    vem_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quot)
    );

    vem_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_sqrt),
        .radicand (quot),
        .done     (sqrt_done),
        .root     (root)
    );

    assign neg_p = OUT_W'(0) - quot[OUT_W-1:0];

    // result selection and saturation
    always_comb
    begin
        out_word_next = out_word_reg;
        if (count_reg == '0)
        begin
            out_word_next.error_value = '0;
            out_word_next.error_flag  = FLAG_EMPTY;
        end
        else if (mode_reg == MODE_RMSE)
        begin
            out_word_next.error_value = OUT_W'(root);
            out_word_next.error_flag  = FLAG_OK;
        end
        else if (mode_reg == MODE_REL)
        begin
            if (x_sum_reg == '0)
            begin
                out_word_next.error_value = '0;
                out_word_next.error_flag  = FLAG_ZERO;
            end
            else if (x_sum_reg[XS_W-1])
            begin
                if (|quot[DVD_W-1:OUT_W] || (quot[OUT_W-1] && |quot[OUT_W-2:0]))
                begin
                    out_word_next.error_value = OUT_MIN;
                    out_word_next.error_flag  = FLAG_SAT;
                end
                else
                begin
                    out_word_next.error_value = neg_p;
                    out_word_next.error_flag  = FLAG_OK;
                end
            end
            else if (|quot[DVD_W-1:OUT_W-1])
            begin
                out_word_next.error_value = OUT_MAX;
                out_word_next.error_flag  = FLAG_SAT;
            end
            else
            begin
                out_word_next.error_value = {1'b0, quot[OUT_W-2:0]};
                out_word_next.error_flag  = FLAG_OK;
            end
        end
        else if (|quot[DVD_W-1:OUT_W-1])
        begin
            out_word_next.error_value = OUT_MAX;
            out_word_next.error_flag  = FLAG_SAT;
        end
        else
        begin
            out_word_next.error_value = {1'b0, quot[OUT_W-2:0]};
            out_word_next.error_flag  = FLAG_OK;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_MSE;
            sq_sum_reg    <= '0;
            x_sum_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_data;
            sq_sum_reg    <= sq_sum_next;
            x_sum_reg     <= x_sum_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_prod)
            prod_reg <= root * count_reg;
        if (cmd.load_out)
            out_word_reg <= out_word_next;
    end

    assign status.div_done  = div_done;
    assign status.sqrt_done = sqrt_done;
    assign status.n_zero    = count_reg == '0;
    assign status.x_zero    = x_sum_reg == '0;
    assign status.mode_root = mode_reg == MODE_RMSE || mode_reg == MODE_REL;
    assign status.mode_rel  = mode_reg == MODE_REL;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> count_reg == '0 && x_sum_reg == '0 && sq_sum_reg == '0)
        else $error("accumulators not cleared after result");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc && !cmd.load_out && room |=> count_reg == $past(count_reg) + 1'b1)
        else $error("pair count did not advance");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("result loaded over a pending word");

endmodule

/* sv/vem_ctrl.sv */
`timescale 1ns / 1ps
module vem_ctrl
    import vem_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_last,
    output logic        in_ready,
    input  vem_status_t status,
    output vem_cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b00000001,
        S_CALC    = 8'b00000010,
        S_DIV1    = 8'b00000100,
        S_SQRT    = 8'b00001000,
        S_MUL     = 8'b00010000,
        S_DIV2_GO = 8'b00100000,
        S_DIV2    = 8'b01000000,
        S_OUT     = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.acc = 1'b1;
                    if (in_last)
                        state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (status.n_zero)
                    state_next = S_OUT;
                else
                begin
                    cmd.start_div1 = 1'b1;
                    state_next     = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (status.div_done)
                begin
                    if (status.mode_root)
                    begin
                        cmd.start_sqrt = 1'b1;
                        state_next     = S_SQRT;
                    end
                    else
                        state_next = S_OUT;
                end
            end
            S_SQRT:
            begin
                if (status.sqrt_done)
                    state_next = (status.mode_rel && !status.x_zero) ? S_MUL : S_OUT;
            end
            S_MUL:
            begin
                cmd.load_prod = 1'b1;
                state_next    = S_DIV2_GO;
            end
            S_DIV2_GO:
            begin
                cmd.start_div2 = 1'b1;
                state_next     = S_DIV2;
            end
            S_DIV2:
            begin
                if (status.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> state_reg == S_CALC)
        else $error("last word did not start the result");

    a_out_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> in_ready)
        else $error("not ready after result");

endmodule

/* sv/vector_error_metric_unit.sv */
`timescale 1ns / 1ps
// input: a word without last_pair is taken in S_IDLE, one word per cycle while in_ready is high
// last word, mse: S_CALC, an 82-step divide, then the output register
// last word, rmse: the divide, then a 41-step square root
// last word, rmse over mean: then a multiply and a second 82-step divide
// input stays blocked until the result is loaded; a held output word adds its stall
// reset: async active low, clears mode (mse), accumulators and output valid
module vector_error_metric_unit
    import vem_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_word_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_word_t  out_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_data
);

    // command and status between the sequencer and the datapath
    vem_cmd_t    cmd;
    vem_status_t status;

    // sequencer: accumulates words, then runs the divide and, by mode, root and second divide
    vem_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_data.last_pair),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: accumulators, shared divider, square root, output register
    vem_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
